// File: rtl/aes_pkg.sv
// AES-128 package: S-box, GF helpers, round function and key step.
package aes_pkg;

    localparam int ROUNDS = 10;
    localparam int BLOCK_W = 128;
    localparam int HALF_W = 64;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW = 1'b1;

    typedef logic [BLOCK_W-1:0] block_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // byte i of the state, byte 0 in the top bits
    function automatic logic [7:0] get_byte(block_t b, int i);
        return b[BLOCK_W-1-8*i -: 8];
    endfunction

    function automatic logic [7:0] gf_double(logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // one cipher round; last drops MixColumns
    function automatic block_t aes_round(block_t s, block_t k, logic last);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        block_t o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[r + 4*c] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
        if (!last)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                all = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
                t[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
                t[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
                t[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++)
            o[BLOCK_W-1-8*i -: 8] = t[i];
        return o ^ k;
    endfunction

    // next round key from the previous one
    function automatic block_t key_step(block_t p, logic [7:0] rc);
        logic [7:0] t [4];
        block_t o;
        for (int j = 0; j < 4; j++)
            t[j] = SBOX[get_byte(p, 12 + ((j + 1) % 4))];
        t[0] = t[0] ^ rc;
        for (int w = 0; w < 4; w++)
            for (int j = 0; j < 4; j++)
            begin
                t[j] = t[j] ^ get_byte(p, 4*w + j);
                o[BLOCK_W-1-8*(4*w+j) -: 8] = t[j];
            end
        return o;
    endfunction

endpackage

// File: rtl/aes128_encrypt_with_key_schedule.sv
// AES-128 encryption: key registers, key expansion, an input AddRoundKey stage and
// ten round stages, registered in turn. One item per cycle unless the output stalls;
// each stage is one round (S-box, MixColumns, XOR). Round keys settle after a key
// write; the user keeps it to the idle window, the block does not enforce that.
// Reset (rst_n low, async) clears the key registers and all stage valid bits.
module aes128_encrypt_with_key_schedule
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [aes_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [aes_pkg::HALF_W-1:0]    cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [127:0]                  s_axis_tdata,  // plain_low, plain_high
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [127:0]                  m_axis_tdata   // cipher_low, cipher_high
);
    localparam int N = aes_pkg::ROUNDS;

    logic [aes_pkg::HALF_W-1:0]  key_high_reg, key_low_reg;
    logic [aes_pkg::BLOCK_W-1:0] rkey [N+1];
    logic                        v_reg;
    logic [aes_pkg::BLOCK_W-1:0] d_reg;
    logic                        v0_ready;
    logic                        sv [N+1];
    logic                        sr [N+1];
    logic [aes_pkg::BLOCK_W-1:0] sd [N+1];

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                aes_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                aes_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    aes_keysched u_ks (.clk(clk), .key({key_high_reg, key_low_reg}), .rkey(rkey));

    // input stage: initial AddRoundKey
    assign v0_ready      = !v_reg || sr[0];
    assign s_axis_tready = v0_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (v0_ready)
            v_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (v0_ready && s_axis_tvalid)
            d_reg <= {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^ rkey[0];
    end

    assign sv[0] = v_reg;
    assign sd[0] = d_reg;

    // round stages
    for (genvar r = 1; r <= N; r++)
    begin : g_round
        aes_round_stage u_rs (
            .clk(clk), .rst_n(rst_n), .last(r == N),
            .in_valid(sv[r-1]), .in_ready(sr[r-1]), .in_data(sd[r-1]),
            .rkey(rkey[r]),
            .out_valid(sv[r]), .out_ready(sr[r]), .out_data(sd[r])
        );
    end

    assign sr[N]         = m_axis_tready;
    assign m_axis_tvalid = sv[N];
    assign m_axis_tdata  = {sd[N][63:0], sd[N][127:64]};

    // input stage holds its item while the first round stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg && !sr[0]) |=> (v_reg && $stable(d_reg)))
        else $error("input stage lost item under stall");
    // output never drops while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output changed under stall");
    // ready reflects stage occupancy
    assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg |-> s_axis_tready)
        else $error("empty input stage not ready");
endmodule

// File: rtl/aes_keysched.sv
// Round key expansion, registered one round key per stage.
module aes_keysched
(
    input  logic                  clk,
    input  logic [aes_pkg::BLOCK_W-1:0] key,
    output logic [aes_pkg::BLOCK_W-1:0] rkey [aes_pkg::ROUNDS+1]
);
    logic [aes_pkg::BLOCK_W-1:0] rk_reg [aes_pkg::ROUNDS+1];
    logic [7:0] rcon [aes_pkg::ROUNDS];

    // round constants by doubling
    always_comb
    begin
        rcon[0] = 8'h01;
        for (int r = 1; r < aes_pkg::ROUNDS; r++)
            rcon[r] = aes_pkg::gf_double(rcon[r-1]);
    end

    // key is static while items flow, so registered chain is exact once settled
    always_ff @(posedge clk)
    begin
        rk_reg[0] <= key;
        for (int r = 1; r <= aes_pkg::ROUNDS; r++)
            rk_reg[r] <= aes_pkg::key_step(rk_reg[r-1], rcon[r-1]);
    end

    assign rkey = rk_reg;
endmodule

// File: rtl/aes_round_stage.sv
// One pipeline stage: a cipher round with valid and stall handling.
module aes_round_stage
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        last,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [aes_pkg::BLOCK_W-1:0] in_data,
    input  logic [aes_pkg::BLOCK_W-1:0] rkey,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [aes_pkg::BLOCK_W-1:0] out_data
);
    logic                        valid_reg;
    logic [aes_pkg::BLOCK_W-1:0] data_reg;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= aes_pkg::aes_round(in_data, rkey, last);
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

// File: tb/tb_aes128_encrypt_with_key_schedule.sv
// Self-checking stream testbench for the AES-128 encryption block.
`timescale 1ns / 1ps

module tb_aes128_encrypt_with_key_schedule;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } block_pair_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [aes_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [aes_pkg::HALF_W-1:0]    cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;

    block_pair_t plain_q[$];
    block_pair_t cipher_q[$];
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    int          mismatches;
    bit          no_idle;
    int          hold_req;
    int          hold_seen;
    int          hold_left;
    int          quiet_cycles;

    aes128_encrypt_with_key_schedule u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),  // plain_low, plain_high
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)   // cipher_low, cipher_high
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // GF(2^8) multiply by x
    function automatic logic [7:0] xtime(logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // full AES-128 encryption of one block, round keys expanded on the fly
    function automatic block_pair_t encrypt_block(logic [63:0] kh, logic [63:0] kl,
                                                  block_pair_t p);
        logic [7:0]  st [16];
        logic [7:0]  tmp [16];
        logic [7:0]  rk [16];
        logic [7:0]  w [4];
        logic [7:0]  rcon;
        logic [7:0]  a0, a1, a2, a3, sum;
        logic [127:0] kv, pv, ov;
        block_pair_t res;
        kv = {kh, kl};
        pv = {p.hi, p.lo};
        rcon = 8'h01;
        for (int i = 0; i < 16; i++)
        begin
            rk[i] = kv[127-8*i -: 8];
            st[i] = pv[127-8*i -: 8] ^ rk[i];
        end
        for (int r = 1; r <= aes_pkg::ROUNDS; r++)
        begin
            // next round key
            for (int j = 0; j < 4; j++)
                w[j] = aes_pkg::SBOX[rk[12 + ((j + 1) % 4)]];
            w[0] = w[0] ^ rcon;
            for (int c = 0; c < 4; c++)
                for (int j = 0; j < 4; j++)
                begin
                    w[j] = w[j] ^ rk[4*c + j];
                    rk[4*c + j] = w[j];
                end
            rcon = xtime(rcon);
            // SubBytes and ShiftRows
            for (int c = 0; c < 4; c++)
                for (int j = 0; j < 4; j++)
                    tmp[j + 4*c] = aes_pkg::SBOX[st[j + 4*((c + j) % 4)]];
            // MixColumns except in the last round
            if (r < aes_pkg::ROUNDS)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
                    sum = a0 ^ a1 ^ a2 ^ a3;
                    tmp[4*c]   = a0 ^ sum ^ xtime(a0 ^ a1);
                    tmp[4*c+1] = a1 ^ sum ^ xtime(a1 ^ a2);
                    tmp[4*c+2] = a2 ^ sum ^ xtime(a2 ^ a3);
                    tmp[4*c+3] = a3 ^ sum ^ xtime(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++)
                st[i] = tmp[i] ^ rk[i];
        end
        for (int i = 0; i < 16; i++)
            ov[127-8*i -: 8] = st[i];
        res.hi = ov[127:64];
        res.lo = ov[63:0];
        return res;
    endfunction

    // input driver: offers queued plaintext items, idles at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                cipher_q.push_back(encrypt_block(key_hi, key_lo, plain_q[0]));
                void'(plain_q.pop_front());
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (plain_q.size() > 0 && (no_idle || $urandom_range(99) >= 17))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {plain_q[0].lo, plain_q[0].hi};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output monitor: checks ciphertext items, stalls at random or for a long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_seen     <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (cipher_q.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected item: got hi=%h lo=%h",
                                 m_axis_tdata[63:0], m_axis_tdata[127:64]);
                end
                else
                begin
                    if (m_axis_tdata[63:0] !== cipher_q[0].hi ||
                        m_axis_tdata[127:64] !== cipher_q[0].lo)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: exp hi=%h lo=%h got hi=%h lo=%h",
                                     cipher_q[0].hi, cipher_q[0].lo,
                                     m_axis_tdata[63:0], m_axis_tdata[127:64]);
                    end
                    void'(cipher_q.pop_front());
                end
            end
            if (hold_req != hold_seen)
            begin
                hold_seen     <= hold_req;
                hold_left     <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= no_idle || $urandom_range(99) >= 17;
        end
    end

    // watchdog on cycles with no accepted item
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic wait_drained();
        while (plain_q.size() != 0 || cipher_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_key(logic [63:0] kh, logic [63:0] kl);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= aes_pkg::REG_KEY_HIGH;
        cfg_data  <= kh;
        @(posedge clk);
        cfg_index <= aes_pkg::REG_KEY_LOW;
        cfg_data  <= kl;
        @(posedge clk);
        cfg_we    <= 1'b0;
        key_hi = kh;
        key_lo = kl;
        // round keys need a pipeline depth to settle
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 64'h5555_5555_5555_5555;
            3: return 64'haaaa_aaaa_aaaa_aaaa;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic push_plain(logic [63:0] hi, logic [63:0] lo);
        block_pair_t p;
        p.hi = hi;
        p.lo = lo;
        plain_q.push_back(p);
    endtask

    // stimulus sequencing
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        key_hi        = '0;
        key_lo        = '0;
        mismatches    = 0;
        no_idle       = 1'b0;
        hold_req      = 0;
        quiet_cycles  = 0;
        repeat (6) @(posedge clk);
        rst_n = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);

        // key never written: all-zero key
        push_plain('0, '0);
        push_plain('1, '1);
        push_plain(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
        wait_drained();

        // standard test key and vector, plus extremes
        load_key(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f);
        push_plain(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
        push_plain('0, '0);
        push_plain('1, '1);
        push_plain(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        push_plain(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        push_plain(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
        wait_drained();

        load_key('1, '1);
        push_plain('0, '0);
        push_plain('1, '1);
        push_plain(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        wait_drained();

        load_key(64'h2b7e_1516_28ae_d2a6, 64'habf7_1588_09cf_4f3c);
        push_plain(64'h3243_f6a8_885a_308d, 64'h3132_9876_5469_4c3f);
        wait_drained();

        // random phases: fresh key each, one without idling, one with a long hold
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 7)
                load_key('0, '0);
            else
                load_key(rand_word(), rand_word());
            no_idle = (ph == 2);
            for (int n = 0; n < 235; n++)
                push_plain(rand_word(), rand_word());
            if (ph == 4)
            begin
                @(posedge clk);
                hold_req <= hold_req + 1;
            end
            wait_drained();
            no_idle = 1'b0;
        end

        if (mismatches == 0 && cipher_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
rtl/aes_pkg.sv
rtl/aes_keysched.sv
rtl/aes_round_stage.sv
rtl/aes128_encrypt_with_key_schedule.sv
tb/tb_aes128_encrypt_with_key_schedule.sv
